@@ sv/fnv_multiply_chain_hash64_macros.svh @@
// Assertion macros for the word-serial FNV/Murmur string hash.
// Used by the top level only; each check is clocked by clock and held off during reset.
`ifndef FNV_MULTIPLY_CHAIN_HASH64_MACROS_SVH
`define FNV_MULTIPLY_CHAIN_HASH64_MACROS_SVH

`ifndef SYNTHESIS

// ante |-> cons in the same cycle
`define FNVMCH_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante |=> cons in the next cycle
`define FNVMCH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FNVMCH_ASSERT_IMPL(lbl, ante, cons, msg)
`define FNVMCH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/fnvmch_pkg.sv @@
// Shared constants, types and helper functions for the string hash block.
// No dependencies; imported by fnvmch_mul and fnv_multiply_chain_hash64.
`default_nettype none

package fnvmch_pkg;

   localparam logic [63:0] SEED_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MURMUR  = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [63:0] PRIME_FNV64 = 64'd1099511628211;
   localparam int          FOLD_SHIFT  = 33;
   localparam int          WORD_BYTES  = 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED_GO,
      S_SEED_WAIT,
      S_MIX_GO,
      S_MIX_WAIT,
      S_FIN_GO,
      S_FIN_WAIT,
      S_EMIT
   } fnv_state_type;

   typedef enum logic [1:0] {
      STEP_LL,
      STEP_LH,
      STEP_HL
   } mul_step_type;

   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   // byte lane i kept when count > i; counts of 8 and above keep the whole word
   function automatic logic [63:0] byte_keep_mask(input logic [3:0] count);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         mask[i*8 +: 8] = (count > 4'(i)) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

   function automatic logic [63:0] fold33(input logic [63:0] x);
      return x ^ (x >> FOLD_SHIFT);
   endfunction

endpackage

`default_nettype wire

@@ sv/fnvmch_mul.sv @@
// Iterative 64x64 -> low 64-bit multiplier built on one 32x32 multiplier.
// Depends on fnvmch_pkg (request/response structs, step codes).
`default_nettype none

module fnvmch_mul import fnvmch_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type mul_req,
   output mul_rsp_type      mul_rsp
);

   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  acc_ff, acc_in;
   mul_step_type step_ff, step_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [31:0]  mul_x;
   logic [31:0]  mul_y;
   logic [63:0]  pp;
   logic [63:0]  term;

   // low*low, then the two cross terms (only their low halves reach bits 63:32)
   always_comb begin
      mul_x = a_ff[31:0];
      mul_y = b_ff[31:0];
      unique case (step_ff)
         STEP_LL: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         STEP_LH: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         STEP_HL: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
      endcase
   end

   assign pp   = mul_x * mul_y;
   assign term = (step_ff == STEP_LL) ? pp : {pp[31:0], 32'b0};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start && !busy_ff) begin
         a_in    = mul_req.op_a;
         b_in    = mul_req.op_b;
         step_in = STEP_LL;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = ((step_ff == STEP_LL) ? 64'b0 : acc_ff) + term;
         case (step_ff)
            STEP_LL: step_in = STEP_LH;
            STEP_LH: step_in = STEP_HL;
            default: begin
               step_in = STEP_LL;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         step_ff <= STEP_LL;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

`default_nettype wire

@@ sv/fnv_multiply_chain_hash64.sv @@
// Word-serial 64-bit string hash: seed, FNV-style multiply chain, Murmur-style finalize.
// Each 64x64 multiply runs on the shared unit as launch, three 32x32 partial
// products and write-back; a plain word takes one multiply, a first word adds
// the seed multiply, a last word the finalize multiply and the output register.
// Input is taken only in IDLE; a held result blocks input only once the next hash is ready to emit.
// Synchronous active-high reset clears the sequencer, the accumulator and rsp_valid.
`default_nettype none
`include "fnv_multiply_chain_hash64_macros.svh"

module fnv_multiply_chain_hash64 import fnvmch_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // input word channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_bytes_valid,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   input  wire logic [31:0] req_total_length,
   // hash result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_hash_value
);

   fnv_state_type state_ff, state_in;

   // running (unfinalized) hash; architectural state, reset to zero
   logic [63:0] acc_ff, acc_in;
   // captured word, already masked to its valid bytes
   logic [63:0] word_ff, word_in;
   logic        mix_ff, mix_in;
   logic        last_ff, last_in;
   logic [31:0] length_ff, length_in;
   // finalize multiply result, second fold applied on the way to the output register
   logic [63:0] fin_ff, fin_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic        rsp_load;

   logic        req_accept;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   fnvmch_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);

   // capture the transfer; bytes above the valid count are zeroed here
   assign word_in   = req_accept ? (req_data_word & byte_keep_mask(req_bytes_valid)) : word_ff;
   assign mix_in    = req_accept ? (req_bytes_valid != 4'd0) : mix_ff;
   assign last_in   = req_accept ? req_last_word : last_ff;
   assign length_in = req_accept ? req_total_length : length_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_first_word) begin
                  state_in = S_SEED_GO;
               end else if (req_bytes_valid != 4'd0) begin
                  state_in = S_MIX_GO;
               end else if (req_last_word) begin
                  state_in = S_FIN_GO;
               end
            end
         end
         S_SEED_GO:   state_in = S_SEED_WAIT;
         S_SEED_WAIT: begin
            if (mul_rsp.done) begin
               if (mix_ff) begin
                  state_in = S_MIX_GO;
               end else if (last_ff) begin
                  state_in = S_FIN_GO;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MIX_GO:    state_in = S_MIX_WAIT;
         S_MIX_WAIT: begin
            if (mul_rsp.done) begin
               state_in = last_ff ? S_FIN_GO : S_IDLE;
            end
         end
         S_FIN_GO:    state_in = S_FIN_WAIT;
         S_FIN_WAIT: begin
            if (mul_rsp.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // wait only while an older result is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.op_a  = acc_ff;
      mul_req.op_b  = PRIME_FNV64;
      acc_in        = acc_ff;
      fin_in        = fin_ff;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_SEED_GO: begin
            // length * murmur constant
            mul_req.start = 1'b1;
            mul_req.op_a  = {32'b0, length_ff};
            mul_req.op_b  = MIX_MURMUR;
         end
         S_SEED_WAIT: begin
            if (mul_rsp.done) begin
               acc_in = SEED_GOLDEN ^ mul_rsp.product;
            end
         end
         S_MIX_GO: begin
            mul_req.start = 1'b1;
            mul_req.op_a  = acc_ff ^ word_ff;
            mul_req.op_b  = PRIME_FNV64;
         end
         S_MIX_WAIT: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
            end
         end
         S_FIN_GO: begin
            // accumulator stays unfinalized; only the copy is folded
            mul_req.start = 1'b1;
            mul_req.op_a  = fold33(acc_ff);
            mul_req.op_b  = MIX_MURMUR;
         end
         S_FIN_WAIT: begin
            if (mul_rsp.done) begin
               fin_in = mul_rsp.product;
            end
         end
         S_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_hash_in  = rsp_load ? fold33(fin_ff) : rsp_hash_ff;

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      mix_ff      <= mix_in;
      last_ff     <= last_in;
      length_ff   <= length_in;
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= 64'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // checks
   `FNVMCH_ASSERT_IMPL(a_no_accept_while_mul, mul_rsp.busy, req_stall, "transfer possible while multiply runs")
   `FNVMCH_ASSERT_IMPL(a_done_in_wait, mul_rsp.done, (state_ff == S_SEED_WAIT || state_ff == S_MIX_WAIT || state_ff == S_FIN_WAIT), "multiply finished outside a wait state")
   `FNVMCH_ASSERT_NEXT(a_rsp_drains, rsp_valid && !rsp_stall && state_ff != S_EMIT, !rsp_valid, "result repeated after transfer")
   `FNVMCH_ASSERT_NEXT(a_empty_word_idle, req_valid && !req_stall && !req_first_word && !req_last_word && req_bytes_valid == 4'd0, state_ff == S_IDLE, "empty word started work")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for fnv_multiply_chain_hash64: string words in, finalized hashes out.
// Needs fnvmch_pkg and the block's RTL only; it keeps its own model of the hash chain.
`timescale 1ns / 100ps

module testbench;

   // hash constants, kept local so the expected values do not lean on the RTL package
   localparam logic [63:0] GOLDEN_SEED  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MURMUR_MULT  = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [63:0] FNV64_PRIME  = 64'd1099511628211;
   localparam int          FINAL_SHIFT  = 33;
   localparam int          LANES        = 8;     // bytes per word
   localparam int          ITEM_TARGET  = 1050;  // words to queue, at least
   localparam int          CYCLE_LIMIT  = 250000;
   localparam int          DRAIN_CYCLES = 40;    // drain window, longer than the deepest word
   localparam int          MAX_PRINTS   = 40;

   typedef struct {
      logic [63:0] data_word;
      logic [3:0]  bytes_valid;
      logic        first_word;
      logic        last_word;
      logic [31:0] total_length;
   } hash_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_word    = '0;
   logic [3:0]  req_bytes_valid  = '0;
   logic        req_first_word   = 1'b0;
   logic        req_last_word    = 1'b0;
   logic [31:0] req_total_length = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_hash_value;

   hash_word_type word_backlog[$];   // words not yet put on the bus
   logic [63:0]   pending_hashes[$]; // hashes predicted, not yet returned
   logic [63:0]   chain_acc;         // model accumulator (unfinalized hash)

   int            error_count = 0;
   int            cycle_count = 0;
   int            send_hold;         // idle cycles before the next word goes out
   int            send_calm = 0;     // words left in a no-idle stretch
   int            take_hold;         // stall cycles owed on the next result
   int            take_calm = 0;
   hash_word_type next_word;
   logic [63:0]   want_hash;

   fnv_multiply_chain_hash64 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_bytes_valid  (req_bytes_valid),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   // Wait drawn per transfer at random, with the odd run of back-to-back transfers.
   function automatic int draw_wait(inout int calm_run);
      if (calm_run > 0) begin
         calm_run--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_run = $urandom_range(10, 40);
      end
      return $urandom_range(0, 6);
   endfunction

   // Model of one accepted word: optional seed, masked XOR + FNV multiply,
   // and on a last word the shift-multiply-shift finalize.
   function automatic void absorb_word(input hash_word_type w);
      logic [63:0] kept;
      logic [63:0] mixed;
      int          lane;
      if (w.first_word) begin
         chain_acc = GOLDEN_SEED ^ (64'(w.total_length) * MURMUR_MULT);
      end
      // counts of 9..15 keep the whole word, same as 8
      if (w.bytes_valid != 4'd0) begin
         kept = w.data_word;
         for (lane = 0; lane < LANES; lane++) begin
            if (w.bytes_valid <= 4'(lane)) begin
               kept[lane*8 +: 8] = 8'h00;
            end
         end
         chain_acc = (chain_acc ^ kept) * FNV64_PRIME;
      end
      // accumulator stays unfinalized after a last word; a later unmarked
      // word keeps chaining from it
      if (w.last_word) begin
         mixed = chain_acc ^ (chain_acc >> FINAL_SHIFT);
         mixed = mixed * MURMUR_MULT;
         mixed = mixed ^ (mixed >> FINAL_SHIFT);
         pending_hashes = {pending_hashes, mixed};
      end
   endfunction

   task automatic queue_word(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic first, input logic last, input logic [31:0] len);
      hash_word_type w;
      w.data_word    = data;
      w.bytes_valid  = nbytes;
      w.first_word   = first;
      w.last_word    = last;
      w.total_length = len;
      word_backlog = {word_backlog, w};
   endtask

   // A string of nbytes as ceil(nbytes/8) words (one empty word for length 0).
   // Bytes above the valid count carry junk so the masking is exercised.
   // When cut is set the string may stop early and never gets its last mark.
   task automatic queue_string(input int unsigned nbytes, input bit cut);
      int unsigned n_words;
      int unsigned n_sent;
      int unsigned left;
      int unsigned w;
      logic [31:0] len_field;
      n_words = (nbytes + LANES - 1) / LANES;
      if (n_words == 0) begin
         n_words = 1;
      end
      n_sent = cut ? $urandom_range(1, n_words) : n_words;
      for (w = 0; w < n_sent; w++) begin
         left = nbytes - w * LANES;
         // length only counts on the first word; elsewhere it is noise
         len_field = (w == 0) ? nbytes : $urandom;
         queue_word({$urandom, $urandom}, (left >= LANES) ? 4'd8 : 4'(left),
                    w == 0, !cut && (w == n_words - 1), len_field);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: directed corner cases first, then random strings and noise.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int pick;

      // empty string: seed then finalize, nothing mixed
      queue_word('1, 4'd0, 1'b1, 1'b1, 32'd0);
      // single full word, all ones
      queue_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
      // single byte; the other seven lanes are masked off
      queue_word('1, 4'd1, 1'b1, 1'b1, 32'd1);
      // zero data, zero length
      queue_word('0, 4'd8, 1'b1, 1'b1, 32'd0);
      // largest length in the seed; last word with an oversized byte count
      queue_word('0, 4'd8, 1'b1, 1'b0, 32'hFFFF_FFFF);
      queue_word('1, 4'd15, 1'b0, 1'b1, 32'hFFFF_FFFF);
      // empty word in the middle of a string mixes nothing
      queue_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1, 1'b0, 32'd12);
      queue_word(64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b0, 1'b0, 32'd12);
      queue_word(64'hFEDC_BA98_7654_3210, 4'd4, 1'b0, 1'b1, 32'd12);
      // new first word while a string is open: the open one is dropped
      queue_word({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 32'd20);
      queue_word({$urandom, $urandom}, 4'd5, 1'b1, 1'b1, 32'd5);
      // words with no open string chain onto the leftover accumulator
      queue_word({$urandom, $urandom}, 4'd3, 1'b0, 1'b0, 32'd0);
      queue_word({$urandom, $urandom}, 4'd9, 1'b0, 1'b1, 32'd0);
      // first and last together with a count above eight
      queue_word({$urandom, $urandom}, 4'd12, 1'b1, 1'b1, 32'd7);
      // short well-formed strings across the word boundary
      queue_string(7, 1'b0);
      queue_string(9, 1'b0);
      queue_string(16, 1'b0);

      // Mostly well-formed strings with random bytes; the rest are strings
      // cut short and loose words with every field random.
      while (word_backlog.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            queue_string($urandom_range(0, 40), 1'b0);
         end else if (pick < 78) begin
            queue_string($urandom_range(41, 300), 1'b0);
         end else if (pick < 86) begin
            queue_string($urandom_range(1, 60), 1'b1);
         end else begin
            queue_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                       1'($urandom), 1'($urandom), $urandom);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // done once every word is taken and every hash is back,
      // then a drain window to catch stray results
      forever begin
         @(posedge clock);
         if (word_backlog.size() == 0 && !req_valid && pending_hashes.size() == 0) begin
            break;
         end
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: one word per transfer, random idle cycles between words.
   // The model runs on the payload at the edge where the transfer happens.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         // model accumulator clears with the block
         chain_acc = '0;
         send_hold = draw_wait(send_calm);
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word('{req_data_word, req_bytes_valid, req_first_word,
                          req_last_word, req_total_length});
         end
         // bus is free: either nothing was up, or the word just went through
         if (!req_valid || !req_stall) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (word_backlog.size() > 0) begin
               next_word = word_backlog.pop_front();
               req_data_word    <= next_word.data_word;
               req_bytes_valid  <= next_word.bytes_valid;
               req_first_word   <= next_word.first_word;
               req_last_word    <= next_word.last_word;
               req_total_length <= next_word.total_length;
               req_valid        <= 1'b1;
               send_hold = draw_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stalls each result for a random count of cycles while it is
   // offered, then checks it against the oldest predicted hash.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         take_hold = draw_wait(take_calm);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hashes.size() == 0) begin
               report_error($sformatf("hash %h returned with none pending", rsp_hash_value));
            end else begin
               want_hash = pending_hashes.pop_front();
               if (rsp_hash_value !== want_hash) begin
                  report_error($sformatf("hash_value %h, expected %h",
                                         rsp_hash_value, want_hash));
               end
            end
            take_hold = draw_wait(take_calm);
         end else if (rsp_valid && take_hold > 0) begin
            take_hold--;
         end
         rsp_stall <= (take_hold > 0);
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
